>>> rtl/dttu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dttu_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned VALUE_W     = 64;

  // Register indexes, taken from paddr[2].
  localparam logic REG_WIDTH_SELECT = 1'b0;
  localparam logic REG_TERMINATOR   = 1'b1;

  localparam logic [1:0] WIDTH_SELECT_RESET = 2'd3;
  localparam logic [7:0] TERMINATOR_RESET   = 8'd0;

  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;
  localparam logic [1:0] WSEL_64 = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // One classified character as it travels from the front to the back.
  typedef struct packed {
    logic       is_end;
    logic       is_space;
    logic       is_digit;
    logic       is_plus;
    logic       is_minus;
    logic       is_term;
    logic [3:0] digit;
  } tok_t;

  typedef enum logic [5:0] {
    PH_LEAD   = 6'b000001,
    PH_SIGN   = 6'b000010,
    PH_DIGITS = 6'b000100,
    PH_TRAIL  = 6'b001000,
    PH_DONE   = 6'b010000,
    PH_FAIL   = 6'b100000
  } phase_t;

endpackage

`default_nettype wire

>>> rtl/dttu_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dttu_front (
  input  wire logic          in_valid,
  input  wire logic          queue_full,
  input  wire logic [7:0]    char_byte,
  input  wire logic [7:0]    terminator,
  output      logic          push,
  output      dttu_pkg::tok_t tok
);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  logic [7:0] digit_full;

  assign push       = in_valid && !queue_full;
  assign digit_full = char_byte - CH_ZERO;

  always_comb begin
    tok.is_end   = (char_byte == CH_NUL);
    tok.is_space = (char_byte == CH_SPACE) ||
                   (char_byte >= CH_TAB && char_byte <= CH_CR);
    tok.is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
    tok.is_plus  = (char_byte == CH_PLUS);
    tok.is_minus = (char_byte == CH_MINUS);
    // A zero terminator never matches, since a zero byte ends the string.
    tok.is_term  = (char_byte == terminator) && (char_byte != CH_NUL);
    tok.digit    = digit_full[3:0];
  end

endmodule

`default_nettype wire

>>> rtl/dttu_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module dttu_queue #(
  parameter int unsigned DEPTH = dttu_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire dttu_pkg::tok_t push_tok,
  input  wire logic           pop,
  output      logic           full,
  output      logic           not_empty,
  output      dttu_pkg::tok_t head_tok
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  dttu_pkg::tok_t  slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head_tok  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/dttu_back.sv
`timescale 1ns / 1ps
`default_nettype none

module dttu_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [1:0]     width_select,
  input  wire logic           tok_avail,
  input  wire dttu_pkg::tok_t tok,
  output      logic           pop,
  output      logic           out_valid,
  input  wire logic           out_stall,
  output      logic [63:0]    out_value,
  output      logic [1:0]     out_status
);

  localparam int unsigned PROD_W = dttu_pkg::VALUE_W + 4;

  dttu_pkg::phase_t phase_r, phase_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic              ovf_r, ovf_nxt;
  logic              neg_r, neg_nxt;
  logic              junk_r, junk_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [63:0]       out_value_r, out_value_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  logic [63:0]       wmax;
  logic [PROD_W-1:0] acc_ext, prod;
  logic              out_free;

  always_comb begin
    unique case (width_select)
      dttu_pkg::WSEL_8:  wmax = 64'h0000_0000_0000_00FF;
      dttu_pkg::WSEL_16: wmax = 64'h0000_0000_0000_FFFF;
      dttu_pkg::WSEL_32: wmax = 64'h0000_0000_FFFF_FFFF;
      default:           wmax = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  end

  // acc * 10 + digit, kept wide enough that the range test is exact.
  assign acc_ext  = {4'b0, acc_r};
  assign prod     = (acc_ext << 3) + (acc_ext << 1) + {{(PROD_W - 4){1'b0}}, tok.digit};
  assign out_free = !out_valid_r || !out_stall;
  assign pop      = tok_avail && (!tok.is_end || out_free);

  always_comb begin
    phase_nxt      = phase_r;
    acc_nxt        = acc_r;
    ovf_nxt        = ovf_r;
    neg_nxt        = neg_r;
    junk_nxt       = junk_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    if (pop) begin
      if (tok.is_end) begin
        out_valid_nxt = 1'b1;
        out_value_nxt = '0;
        if (phase_r != dttu_pkg::PH_DIGITS && phase_r != dttu_pkg::PH_TRAIL &&
            phase_r != dttu_pkg::PH_DONE) begin
          out_status_nxt = dttu_pkg::ST_INVALID;
        end else if (ovf_r || (acc_r > wmax) || (neg_r && acc_r != '0)) begin
          out_status_nxt = dttu_pkg::ST_RANGE;
        end else if (junk_r) begin
          out_status_nxt = dttu_pkg::ST_INVALID;
        end else begin
          out_status_nxt = dttu_pkg::ST_OK;
          out_value_nxt  = acc_r;
        end
        phase_nxt = dttu_pkg::PH_LEAD;
        acc_nxt   = '0;
        ovf_nxt   = 1'b0;
        neg_nxt   = 1'b0;
        junk_nxt  = 1'b0;
      end else begin
        unique case (phase_r)
          dttu_pkg::PH_LEAD: begin
            if (tok.is_space) begin
              phase_nxt = dttu_pkg::PH_LEAD;
            end else if (tok.is_plus || tok.is_minus) begin
              neg_nxt   = tok.is_minus;
              phase_nxt = dttu_pkg::PH_SIGN;
            end else if (tok.is_digit) begin
              phase_nxt = dttu_pkg::PH_DIGITS;
            end else begin
              phase_nxt = dttu_pkg::PH_FAIL;
            end
          end
          dttu_pkg::PH_SIGN: begin
            phase_nxt = tok.is_digit ? dttu_pkg::PH_DIGITS : dttu_pkg::PH_FAIL;
          end
          dttu_pkg::PH_DIGITS, dttu_pkg::PH_TRAIL: begin
            if (phase_r == dttu_pkg::PH_DIGITS && tok.is_digit) begin
              phase_nxt = dttu_pkg::PH_DIGITS;
            end else if (tok.is_term) begin
              phase_nxt = dttu_pkg::PH_DONE;
            end else if (tok.is_space) begin
              phase_nxt = dttu_pkg::PH_TRAIL;
            end else begin
              junk_nxt  = 1'b1;
              phase_nxt = dttu_pkg::PH_DONE;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase

        // A digit is added on entering or staying in the digit phase if it fits the width.
        if (tok.is_digit && !ovf_r &&
            (phase_r == dttu_pkg::PH_LEAD || phase_r == dttu_pkg::PH_SIGN ||
             phase_r == dttu_pkg::PH_DIGITS)) begin
          if (prod > {4'b0, wmax}) begin
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt = prod[63:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dttu_pkg::PH_LEAD;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      neg_r       <= 1'b0;
      junk_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      neg_r       <= neg_nxt;
      junk_r      <= junk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

>>> rtl/decimal_text_to_unsigned.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   in_char_byte[7:0]
// out_      output     out_valid / out_stall out_value[63:0], out_status[1:0]
// APB       config     psel/penable/pwrite   paddr[2:0], pwdata[31:0], prdata[31:0]
//
// One character is accepted per cycle while in_stall is low; a zero byte passes
// via the queue to the output register and raises out_valid when the path is clear.
// The parser core takes one queued character per clock unless a zero byte waits on
// the output; in_stall is raised only when the two-entry character queue is full.
// A zero byte leaves the queue only when the output register is empty or being taken.
// Reset is synchronous and active low and returns the parser to its leading phase.

module decimal_text_to_unsigned #(
  parameter int unsigned QUEUE_DEPTH = dttu_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  in_char_byte,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [63:0] out_value,
  output      logic [1:0]  out_status,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [dttu_pkg::ADDR_W-1:0] paddr,
  input  wire logic [dttu_pkg::DATA_W-1:0] pwdata,
  output      logic [dttu_pkg::DATA_W-1:0] prdata,
  output      logic        pready
);

  logic [1:0]     width_select_r;
  logic [7:0]     terminator_r;
  logic           reg_idx;
  logic           cfg_write;
  logic           push, queue_full, tok_avail, pop;
  dttu_pkg::tok_t front_tok, head_tok;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_select_r <= dttu_pkg::WIDTH_SELECT_RESET;
      terminator_r   <= dttu_pkg::TERMINATOR_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        dttu_pkg::REG_WIDTH_SELECT: width_select_r <= pwdata[1:0];
        dttu_pkg::REG_TERMINATOR:   terminator_r   <= pwdata[7:0];
        default:                    width_select_r <= width_select_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dttu_pkg::REG_WIDTH_SELECT: prdata = {{(dttu_pkg::DATA_W - 2){1'b0}}, width_select_r};
      dttu_pkg::REG_TERMINATOR:   prdata = {{(dttu_pkg::DATA_W - 8){1'b0}}, terminator_r};
      default:                    prdata = '0;
    endcase
  end

  assign in_stall = queue_full;

  dttu_front u_front (
    .in_valid   (in_valid),
    .queue_full (queue_full),
    .char_byte  (in_char_byte),
    .terminator (terminator_r),
    .push       (push),
    .tok        (front_tok)
  );

  dttu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_tok  (front_tok),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (tok_avail),
    .head_tok  (head_tok)
  );

  dttu_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .width_select (width_select_r),
    .tok_avail    (tok_avail),
    .tok          (head_tok),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_status   (out_status)
  );

endmodule

`default_nettype wire

>>> rtl/dttu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dttu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_value,
  input wire logic [1:0]  out_status
);

  // A held result keeps its value and status.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == dttu_pkg::ST_OK || out_status == dttu_pkg::ST_INVALID ||
                   out_status == dttu_pkg::ST_RANGE))
    else $error("undefined status code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != dttu_pkg::ST_OK |-> out_value == 64'd0)
    else $error("failed parse carries a nonzero value");

  // The character queue only fills after a request was taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("input stall raised without a new request");

endmodule

bind decimal_text_to_unsigned dttu_checker u_dttu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_value  (out_value),
  .out_status (out_status)
);

`default_nettype wire
